// ===== sv/eptw_pkg.sv =====
// Shared types and codes for the four-level table walker.
// Used by eptw_store and ept_four_level_walker_core; no dependencies.
package eptw_pkg;

  // Widths fixed by the request and result fields.
  localparam int unsigned AddrW  = 52;
  localparam int unsigned EntryW = 64;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned PageNW = 40;  // bits 51:12 of a byte address

  // Request kinds carried on tuser.
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Entry bits that the walk tests.
  localparam int unsigned BIT_READ  = 0;
  localparam int unsigned BIT_LARGE = 7;

  // Levels of the walk.
  localparam logic [1:0] LVL_ROOT = 2'd0;
  localparam logic [1:0] LVL_DIR  = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_ABSENT  = 3'd1,
    STAT_LARGE   = 3'd2,
    STAT_OUTSIDE = 3'd3,
    STAT_WRITTEN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [1:0]          level;
    logic [AddrW-1:0]    leaf_addr;
    logic [EntryW-1:0]   leaf_entry;
  } result_t;

endpackage

// ===== sv/eptw_store.sv =====
// Single-port table word store with registered read data.
// Depends on eptw_pkg for the entry width.
module eptw_store
  import eptw_pkg::*;
#(
  parameter int unsigned Depth = 8192,
  parameter int unsigned WordW = 13
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [WordW-1:0]  addr_i,
  input  logic [EntryW-1:0] wdata_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem [Depth];

  // One access per cycle: either a write or a registered read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

// ===== sv/ept_four_level_walker_core.sv =====
// Top level of the four-level extended page table walker.
// Depends on eptw_pkg and eptw_store.
//
//  Channel     Direction  Payload
//  s_axis_*    in         tuser: action; tdata: address, word_data
//  m_axis_*    out        tuser: status; tdata: fault_level, leaf_entry_address, leaf_entry
//  cfg_*       in         root_table_base, written when cfg_we_i is high
//
// A table write completes in the cycle it is accepted. A lookup makes one
// dependent read of the single-port store per level visited (up to four); its
// result is registered. After reset all TABLE_PAGES*512 store words are swept
// to zero, one word a cycle; no request is taken meanwhile. A waiting result
// holds the input off only until it is taken; a result may leave in the cycle
// the next request enters.
module ept_four_level_walker_core
  import eptw_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic         s_axis_tuser,   // [0] action
  input  logic [119:0] s_axis_tdata,   // [51:0] address, [115:52] word_data, rest zero
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [2:0]   m_axis_tuser,   // [2:0] status
  output logic [119:0] m_axis_tdata,   // [1:0] fault_level, [53:2] leaf_entry_address,
                                       // [117:54] leaf_entry, rest zero
  input  logic         cfg_we_i,
  input  logic [51:0]  cfg_wdata_i     // root_table_base
);

  localparam int unsigned PageW      = $clog2(TABLE_PAGES);
  localparam int unsigned WordW      = PageW + IdxW;
  localparam int unsigned StoreWords = TABLE_PAGES * 512;

  state_e              state_q, state_d;
  logic [AddrW-1:0]    root_q;
  logic [WordW-1:0]    clr_q, clr_d;
  logic [1:0]          level_q, level_d;
  logic [35:0]         guest_q, guest_d;     // guest address bits 47:12
  logic [WordW-1:0]    walk_addr_q, walk_addr_d;
  result_t             res_q, res_d;
  logic                out_valid_q, out_valid_d;

  logic                in_acc;
  logic                in_action;
  logic [AddrW-1:0]    in_addr;
  logic [EntryW-1:0]   in_wdata;
  logic                clr_last;
  logic                root_ok;
  logic                wr_ok;
  logic                walk_stop;
  logic                res_load;
  logic [PageNW-1:0]   next_page;
  logic                next_ok;
  logic [1:0]          next_level;
  logic [IdxW-1:0]     next_idx;

  logic                mem_en;
  logic                mem_we;
  logic [WordW-1:0]    mem_addr;
  logic [EntryW-1:0]   mem_wdata;
  logic [EntryW-1:0]   mem_rdata;

  eptw_store #(
    .Depth (StoreWords),
    .WordW (WordW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Request unpacking and handshake.
  assign in_action     = s_axis_tuser;
  assign in_addr       = s_axis_tdata[51:0];
  assign in_wdata      = s_axis_tdata[115:52];
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign clr_last = (clr_q == WordW'(StoreWords - 1));
  assign root_ok  = (root_q[51:12] < PageNW'(TABLE_PAGES));
  assign wr_ok    = (in_addr[51:12] < PageNW'(TABLE_PAGES));

  // Next-table pointer taken from the entry that was just read.
  assign next_page  = mem_rdata[51:12];
  assign next_ok    = (next_page < PageNW'(TABLE_PAGES));
  assign next_level = level_q + 2'd1;

  always_comb begin
    case (next_level)
      2'd1:    next_idx = guest_q[26:18];
      2'd2:    next_idx = guest_q[17:9];
      2'd3:    next_idx = guest_q[8:0];
      default: next_idx = guest_q[35:27];
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && (in_action == ACT_LOOKUP) && root_ok) state_d = S_WALK;
      end
      S_WALK: begin
        if (walk_stop) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Store access, walk registers and result.
  always_comb begin
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = walk_addr_q;
    mem_wdata   = in_wdata;
    clr_d       = clr_q;
    level_d     = level_q;
    guest_d     = guest_q;
    walk_addr_d = walk_addr_q;
    walk_stop   = 1'b0;
    res_load    = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + WordW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          res_d = '{status: STAT_OUTSIDE, level: LVL_ROOT, leaf_addr: '0, leaf_entry: '0};
          if (in_action == ACT_WRITE) begin
            res_load = 1'b1;
            if (wr_ok) begin
              mem_en       = 1'b1;
              mem_we       = 1'b1;
              mem_addr     = in_addr[3 +: WordW];
              res_d.status = STAT_WRITTEN;
            end
          end else if (root_ok) begin
            // Issue the root-level read.
            mem_en      = 1'b1;
            mem_addr    = {root_q[12 +: PageW], in_addr[47:39]};
            walk_addr_d = mem_addr;
            guest_d     = in_addr[47:12];
            level_d     = LVL_ROOT;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      S_WALK: begin
        res_d = '{status: STAT_OUTSIDE, level: level_q, leaf_addr: '0, leaf_entry: '0};
        if (level_q == LVL_LEAF) begin
          walk_stop = 1'b1;
          res_d     = '{status: STAT_OK, level: LVL_LEAF,
                        leaf_addr: AddrW'({walk_addr_q, 3'b000}), leaf_entry: mem_rdata};
        end else if (!mem_rdata[BIT_READ]) begin
          walk_stop    = 1'b1;
          res_d.status = STAT_ABSENT;
        end else if ((level_q == LVL_DIR) && mem_rdata[BIT_LARGE]) begin
          walk_stop    = 1'b1;
          res_d.status = STAT_LARGE;
        end else if (!next_ok) begin
          walk_stop   = 1'b1;
          res_d.level = next_level;
        end else begin
          // Follow the pointer to the next level.
          mem_en      = 1'b1;
          mem_addr    = {next_page[PageW-1:0], next_idx};
          walk_addr_d = mem_addr;
          level_d     = next_level;
        end
        res_load = walk_stop;
      end
      default: ;
    endcase
  end

  // The result register is free or being emptied whenever it is loaded.
  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    level_q     <= level_d;
    guest_q     <= guest_d;
    walk_addr_q <= walk_addr_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // Result packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {2'b00, res_q.leaf_entry, res_q.leaf_addr, res_q.level};

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the four-level table walker: stream driver, result monitor and walk predictor.
// Depends on eptw_pkg and ept_four_level_walker_core; needs no files or arguments at run time.
`timescale 1ns / 1ps

module tb_top;
  import eptw_pkg::*;

  localparam int unsigned TablePages = 16;
  localparam int unsigned StoreWords = TablePages * 512;
  localparam int unsigned LongHold   = 400;

  typedef struct packed {
    logic              act;
    logic [AddrW-1:0]  addr;
    logic [EntryW-1:0] data;
  } walk_req_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic         s_axis_tuser  = 1'b0;
  logic [119:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [2:0]   m_axis_tuser;
  logic [119:0] m_axis_tdata;
  logic         cfg_we_i      = 1'b0;
  logic [51:0]  cfg_wdata_i   = '0;

  // Predictor state: a mirror of the table store and of the root base.
  logic [EntryW-1:0] table_mirror [StoreWords];
  logic [AddrW-1:0]  root_mirror = '0;

  walk_req_t   pending_reqs [$];
  result_t     walk_results_due [$];
  int unsigned owed = 0;
  int unsigned queued_items = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned faults = 0;
  int unsigned root_settings = 0;
  int unsigned tally [5] = '{default: 0};
  logic [39:0] gen_root_page = '0;
  logic        req_fire = 1'b0;
  bit          long_req = 1'b0;

  ept_four_level_walker_core #(
    .TABLE_PAGES(TablePages)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected outcome of one request; a table write also updates the mirror.
  function automatic result_t walk_outcome(logic act, logic [AddrW-1:0] addr,
                                           logic [EntryW-1:0] data);
    result_t           r;
    logic [AddrW-1:0]  base;
    logic [39:0]       page;
    logic [8:0]        idx;
    logic [EntryW-1:0] ent;
    int unsigned       wi;
    r = '0;
    if (act == ACT_WRITE) begin
      if (addr[51:3] >= StoreWords) begin
        r.status = STAT_OUTSIDE;
      end else begin
        table_mirror[int'(addr[51:3])] = data;
        r.status = STAT_WRITTEN;
      end
      return r;
    end
    base = root_mirror;
    for (int lvl = 0; lvl < 4; lvl++) begin
      idx  = addr[(39 - 9 * lvl) +: 9];
      page = base[51:12];
      if (page >= TablePages) begin
        r.status = STAT_OUTSIDE;
        r.level  = 2'(lvl);
        return r;
      end
      wi  = int'(page) * 512 + int'(idx);
      ent = table_mirror[wi];
      if (lvl == 3) begin
        r.status     = STAT_OK;
        r.level      = LVL_LEAF;
        r.leaf_addr  = 52'(wi) << 3;
        r.leaf_entry = ent;
        return r;
      end
      if (!ent[BIT_READ]) begin
        r.status = STAT_ABSENT;
        r.level  = 2'(lvl);
        return r;
      end
      if (2'(lvl) == LVL_DIR && ent[BIT_LARGE]) begin
        r.status = STAT_LARGE;
        r.level  = LVL_DIR;
        return r;
      end
      base = {ent[51:12], 12'h000};
    end
    return r;
  endfunction

  // Byte address of entry ix in table page pg.
  function automatic logic [AddrW-1:0] entry_addr(logic [39:0] pg, logic [8:0] ix);
    return {pg, ix, 3'b000};
  endfunction

  // Table entry that points at page pg with the given low flag bits.
  function automatic logic [EntryW-1:0] ptr_entry(logic [39:0] pg, logic [11:0] flags);
    return {12'h000, pg, flags};
  endfunction

  // Mostly pages inside the store, now and then one beyond it.
  function automatic logic [39:0] pick_page();
    logic [39:0] pg;
    case ($urandom_range(0, 31))
      0: pg = 40'(TablePages);
      1: pg = '1;
      2: pg = 40'({$urandom, $urandom});
      default: pg = 40'($urandom_range(0, TablePages - 1));
    endcase
    return pg;
  endfunction

  task automatic queue_req(logic act, logic [AddrW-1:0] addr, logic [EntryW-1:0] data);
    walk_req_t req;
    req.act  = act;
    req.addr = addr;
    req.data = data;
    pending_reqs.push_back(req);
    owed++;
    queued_items++;
  endtask

  // A full chain of table entries followed by a lookup through it, at times with one
  // level broken: read bit clear, or the large-page bit at the directory.
  task automatic queue_walk();
    logic [39:0]       pg [4];
    logic [8:0]        ix [4];
    logic [EntryW-1:0] e;
    logic [AddrW-1:0]  ga;
    int                broken;
    pg[0] = gen_root_page;
    for (int k = 1; k < 4; k++) pg[k] = pick_page();
    for (int k = 0; k < 4; k++) ix[k] = 9'($urandom);
    broken = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      e = {$urandom, $urandom};
      e[51:12] = pg[k + 1];
      e[BIT_READ] = (broken != k);
      if (k == 2) e[BIT_LARGE] = (broken == 3);
      queue_req(ACT_WRITE, entry_addr(pg[k], ix[k]) | 52'($urandom_range(0, 7)), e);
    end
    queue_req(ACT_WRITE, entry_addr(pg[3], ix[3]), {$urandom, $urandom});
    ga = 52'({$urandom, $urandom});
    ga[47:12] = {ix[0], ix[1], ix[2], ix[3]};
    queue_req(ACT_LOOKUP, ga, {$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) begin
      ga[51:48] = 4'($urandom);
      ga[11:0]  = 12'($urandom);
      queue_req(ACT_LOOKUP, ga, {$urandom, $urandom});
    end
  endtask

  // Stray requests: random lookups, random in-store words, random full-width writes.
  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: queue_req(ACT_LOOKUP, 52'({$urandom, $urandom}), {$urandom, $urandom});
      1: queue_req(ACT_WRITE, 52'($urandom_range(0, StoreWords * 8 - 1)), {$urandom, $urandom});
      default: queue_req(ACT_WRITE, 52'({$urandom, $urandom}), {$urandom, $urandom});
    endcase
  endtask

  task automatic write_root(logic [AddrW-1:0] v);
    @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    gen_root_page = v[51:12];
    root_settings++;
  endtask

  task automatic wait_idle();
    wait (owed == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic report_diff(string what, logic [63:0] want, logic [63:0] got);
    faults++;
    $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Request driver: bursts of random length with random gaps; now and then it holds
  // off until every accepted request has returned its result.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  bit          drain_wait = 1'b0;

  always @(negedge clk_i) begin
    walk_req_t nxt;
    if (!rst_ni) begin
      // Held idle during reset.
    end else if (s_axis_tvalid && !req_fire) begin
      // Current request not yet taken.
    end else if (gap_left != 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (drain_wait && (n_accepted != n_results)) begin
      s_axis_tvalid <= 1'b0;
    end else if (pending_reqs.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      drain_wait = 1'b0;
      nxt = pending_reqs.pop_front();
      s_axis_tuser  <= nxt.act;
      s_axis_tdata  <= {4'b0000, nxt.data, nxt.addr};
      s_axis_tvalid <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        burst_left = 40;
        gap_left   = 0;
      end else begin
        burst_left = $urandom_range(1, 20);
        gap_left   = $urandom_range(0, 6);
        drain_wait = ($urandom_range(0, 9) == 0);
      end
    end
  end

  // Result receiver: its own ready pattern, plus one long hold-off on request.
  int unsigned rdy_left = 0;
  int unsigned long_left = 0;
  bit          rdy_high = 1'b0;

  always @(negedge clk_i) begin
    if (long_req) begin
      long_req  = 1'b0;
      long_left = LongHold;
    end
    if (long_left != 0) begin
      long_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_high = !rdy_high;
        if (rdy_high) rdy_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 10);
        else rdy_left = $urandom_range(1, 7);
      end
      rdy_left--;
      m_axis_tready <= rdy_high;
    end
  end

  // Monitor: predicts each accepted request and checks each result against the oldest.
  always @(posedge clk_i) begin
    result_t want;
    req_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) root_mirror = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        walk_results_due.push_back(walk_outcome(s_axis_tuser, s_axis_tdata[51:0],
                                                s_axis_tdata[115:52]));
        n_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (owed != 0) owed--;
        if (walk_results_due.size() == 0) begin
          report_diff("unexpected result, status", 64'd0, 64'(m_axis_tuser));
        end else begin
          want = walk_results_due.pop_front();
          tally[int'(want.status)]++;
          if (m_axis_tuser !== want.status)
            report_diff("status", 64'(want.status), 64'(m_axis_tuser));
          if (m_axis_tdata[1:0] !== want.level)
            report_diff("fault_level", 64'(want.level), 64'(m_axis_tdata[1:0]));
          if (m_axis_tdata[53:2] !== want.leaf_addr)
            report_diff("leaf_entry_address", 64'(want.leaf_addr), 64'(m_axis_tdata[53:2]));
          if (m_axis_tdata[117:54] !== want.leaf_entry)
            report_diff("leaf_entry", want.leaf_entry, m_axis_tdata[117:54]);
        end
      end
    end
  end

  // Run limit, several times the slowest legal run including the store sweep.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus: directed walks first, then random phases under several root bases.
  initial begin
    logic [39:0] pg;
    int unsigned target;
    foreach (table_mirror[i]) table_mirror[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Root at page 0; the low bits of the base are ignored.
    write_root(52'h0_0000_0000_0FFF);
    queue_req(ACT_LOOKUP, '0, '1);                 // empty store: root entry absent
    queue_req(ACT_WRITE, '0, '1);                  // root entry with every bit set
    queue_req(ACT_LOOKUP, '0, '0);                 // its pointer lies beyond the store
    queue_req(ACT_WRITE, 52'h0_0000_0000_FFFF, '0); // last store word, unaligned
    queue_req(ACT_WRITE, 52'h0_0000_0001_0000, '1); // first word past the store
    // Full chain through the highest index at each level.
    queue_req(ACT_WRITE, entry_addr(40'd0, 9'h1FF), ptr_entry(40'd1, 12'h001));
    queue_req(ACT_WRITE, entry_addr(40'd1, 9'h1FF), ptr_entry(40'd2, 12'h001));
    queue_req(ACT_WRITE, entry_addr(40'd2, 9'h1FF), ptr_entry(40'd3, 12'h001));
    queue_req(ACT_WRITE, entry_addr(40'd3, 9'h1FF), '1);
    queue_req(ACT_LOOKUP, '1, '0);
    // Write and execute bits alone do not make an entry present.
    queue_req(ACT_WRITE, entry_addr(40'd1, 9'h1FF), ptr_entry(40'd2, 12'h006));
    queue_req(ACT_LOOKUP, '1, '0);
    // Top bits set, read bit only; the large bit above the directory is ignored.
    queue_req(ACT_WRITE, entry_addr(40'd1, 9'h1FF), {12'hFFF, 40'd2, 12'h001});
    queue_req(ACT_WRITE, entry_addr(40'd0, 9'h1FF), ptr_entry(40'd1, 12'h081));
    queue_req(ACT_LOOKUP, '1, '0);
    // Large page at the directory, then the same without the read bit.
    queue_req(ACT_WRITE, entry_addr(40'd2, 9'h1FF), ptr_entry(40'd3, 12'h081));
    queue_req(ACT_LOOKUP, '1, '0);
    queue_req(ACT_WRITE, entry_addr(40'd2, 9'h1FF), ptr_entry(40'd3, 12'h080));
    queue_req(ACT_LOOKUP, '1, '0);
    // Leaf table beyond the store.
    queue_req(ACT_WRITE, entry_addr(40'd2, 9'h1FF), ptr_entry(40'(TablePages), 12'h001));
    queue_req(ACT_LOOKUP, '1, '0);
    // The leaf entry is returned untested, even when zero; guest bits 51:48 clear.
    queue_req(ACT_WRITE, entry_addr(40'd2, 9'h1FF), ptr_entry(40'd3, 12'hF7F));
    queue_req(ACT_WRITE, entry_addr(40'd3, 9'h1FF), '0);
    queue_req(ACT_LOOKUP, 52'h0_FFFF_FFFF_FFFF, '1);
    queue_req(ACT_LOOKUP, 52'h0_0080_0000_0000, '0); // root index 1 never written

    // Root base at the top of the address range: outside at the root.
    wait_idle();
    write_root('1);
    queue_req(ACT_LOOKUP, '1, '1);
    queue_req(ACT_WRITE, 52'h0_0000_0000_0008, {$urandom, $urandom});

    // Random phases: last page, random pages, and one just past the store.
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: pg = 40'(TablePages - 1);
        5: pg = 40'(TablePages);
        default: pg = 40'($urandom_range(0, TablePages - 1));
      endcase
      write_root({pg, 12'($urandom)});
      target = queued_items + ((ph == 5) ? 30 : 210);
      while (queued_items < target) begin
        if ($urandom_range(0, 3) != 0) queue_walk();
        else queue_noise();
      end
      if (ph == 1) long_req = 1'b1;
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (walk_results_due.size() != 0) begin
      faults++;
      $display("%0t ns: %0d expected results never arrived", $time, walk_results_due.size());
    end
    $display("Run covered %0d requests under %0d root base settings: %0d writes, %0d outside.",
             n_accepted, root_settings, tally[int'(STAT_WRITTEN)], tally[int'(STAT_OUTSIDE)]);
    $display("Walks ended %0d translated, %0d not present, %0d large page.",
             tally[int'(STAT_OK)], tally[int'(STAT_ABSENT)], tally[int'(STAT_LARGE)]);
    if (faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/eptw_pkg.sv
sv/eptw_store.sv
sv/ept_four_level_walker_core.sv
dv/tb_top.sv
